>>> sv/svfr_pkg.sv
// Shared types and constants for the stick velocity frame rotation block.
// Used by every cell module and by the top level; depends on nothing.
package svfr_pkg;

  localparam int ATAN_ENTRIES = 24;

  // Wrap constants for Q4.12 angles.
  localparam logic signed [16:0] PI_Q12      = 17'sd12868;
  localparam logic signed [16:0] TWO_PI_Q12  = 17'sd25736;
  localparam logic signed [16:0] FOUR_PI_Q12 = 17'sd51472;
  localparam logic signed [15:0] HALF_PI_Q12 = 16'sd6434;

  // Reciprocal of the CORDIC gain, Q0.16.
  localparam logic signed [16:0] INV_K_Q16 = 17'sd39797;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MAX_SPEED   = 2'd0;
  localparam logic [1:0] CFG_YAW_ZERO    = 2'd1;
  localparam logic [1:0] CFG_REMOTE_GAIN = 2'd2;
  localparam logic [1:0] CFG_COMP_GAIN   = 2'd3;

  // Values that ride along the pipeline next to the arithmetic of each cell.
  typedef struct packed {
    logic signed [17:0] rx;
    logic signed [17:0] ry;
    logic [16:0]        lim;
    logic               norm;
    logic signed [15:0] ang;
    logic signed [15:0] avx;
    logic signed [15:0] avy;
    logic [31:0]        kp;
  } side_t;

  // Arctangent of 2^-idx in Q4.28 radians.
  function automatic logic signed [31:0] atan_q28(input int idx);
    logic signed [31:0] v;
    case (idx)
      0:  v = 32'sd210828714;
      1:  v = 32'sd124459457;
      2:  v = 32'sd65760959;
      3:  v = 32'sd33381290;
      4:  v = 32'sd16755422;
      5:  v = 32'sd8385879;
      6:  v = 32'sd4193963;
      7:  v = 32'sd2097109;
      8:  v = 32'sd1048571;
      9:  v = 32'sd524287;
      10: v = 32'sd262144;
      11: v = 32'sd131072;
      12: v = 32'sd65536;
      13: v = 32'sd32768;
      14: v = 32'sd16384;
      15: v = 32'sd8192;
      16: v = 32'sd4096;
      17: v = 32'sd2048;
      18: v = 32'sd1024;
      19: v = 32'sd512;
      20: v = 32'sd256;
      21: v = 32'sd128;
      22: v = 32'sd64;
      23: v = 32'sd32;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/svfr_sqrt_cell.sv
// One digit cell of the pipelined integer square root.
// Depends on svfr_pkg for the side-band type.
module svfr_sqrt_cell #(
  parameter int BIT = 16
) (
  input  logic              clk_i,
  input  logic              ce_i,
  input  logic [35:0]       rem_i,
  input  logic [16:0]       root_i,
  input  svfr_pkg::side_t   side_i,
  output logic [35:0]       rem_o,
  output logic [16:0]       root_o,
  output svfr_pkg::side_t   side_o
);

  logic [35:0] trial;
  logic [35:0] rem_q;
  logic [16:0] root_q;
  svfr_pkg::side_t side_q;

  // rem holds n - root^2; adding 2^BIT to the root costs 2*root*2^BIT + 2^(2*BIT).
  assign trial = ({19'd0, root_i} << (BIT + 1)) + (36'd1 << (2 * BIT));

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      if (rem_i >= trial) begin
        rem_q  <= rem_i - trial;
        root_q <= root_i | (17'd1 << BIT);
      end else begin
        rem_q  <= rem_i;
        root_q <= root_i;
      end
      side_q <= side_i;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign side_o = side_q;

endmodule

>>> sv/svfr_div_cell.sv
// One quotient-bit cell of the two-lane restoring divider.
// Depends on svfr_pkg for the side-band type.
module svfr_div_cell #(
  parameter int BIT = 16
) (
  input  logic              clk_i,
  input  logic              ce_i,
  input  logic [35:0]       remx_i,
  input  logic [35:0]       remy_i,
  input  logic [17:0]       den_i,
  input  logic [16:0]       qx_i,
  input  logic [16:0]       qy_i,
  input  svfr_pkg::side_t   side_i,
  output logic [35:0]       remx_o,
  output logic [35:0]       remy_o,
  output logic [17:0]       den_o,
  output logic [16:0]       qx_o,
  output logic [16:0]       qy_o,
  output svfr_pkg::side_t   side_o
);

  logic [35:0] trial;
  logic [35:0] remx_q, remy_q;
  logic [17:0] den_q;
  logic [16:0] qx_q, qy_q;
  svfr_pkg::side_t side_q;

  assign trial = {18'd0, den_i} << BIT;

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      if (remx_i >= trial) begin
        remx_q <= remx_i - trial;
        qx_q   <= qx_i | (17'd1 << BIT);
      end else begin
        remx_q <= remx_i;
        qx_q   <= qx_i;
      end
      if (remy_i >= trial) begin
        remy_q <= remy_i - trial;
        qy_q   <= qy_i | (17'd1 << BIT);
      end else begin
        remy_q <= remy_i;
        qy_q   <= qy_i;
      end
      den_q  <= den_i;
      side_q <= side_i;
    end
  end

  assign remx_o = remx_q;
  assign remy_o = remy_q;
  assign den_o  = den_q;
  assign qx_o   = qx_q;
  assign qy_o   = qy_q;
  assign side_o = side_q;

endmodule

>>> sv/svfr_cordic_cell.sv
// One micro-rotation cell of the CORDIC rotation chain.
// Depends on svfr_pkg for the arctangent table and the side-band type.
module svfr_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic               clk_i,
  input  logic               ce_i,
  input  logic signed [35:0] x_i,
  input  logic signed [35:0] y_i,
  input  logic signed [31:0] z_i,
  input  svfr_pkg::side_t    side_i,
  output logic signed [35:0] x_o,
  output logic signed [35:0] y_o,
  output logic signed [31:0] z_o,
  output svfr_pkg::side_t    side_o
);

  logic signed [35:0] dx, dy;
  logic signed [31:0] at;
  logic signed [35:0] x_q, y_q;
  logic signed [31:0] z_q;
  svfr_pkg::side_t side_q;

  assign dx = y_i >>> IDX;
  assign dy = x_i >>> IDX;
  assign at = svfr_pkg::atan_q28(IDX);

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      if (!z_i[31]) begin
        x_q <= x_i - dx;
        y_q <= y_i + dy;
        z_q <= z_i - at;
      end else begin
        x_q <= x_i + dx;
        y_q <= y_i - dy;
        z_q <= z_i + at;
      end
      side_q <= side_i;
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign side_o = side_q;

endmodule

>>> sv/stick_velocity_frame_rotate.sv
// Stick to chassis-frame velocity transform: scaling, length limit, rotation, compensation.
// Depends on svfr_pkg, svfr_sqrt_cell, svfr_div_cell and svfr_cordic_cell.
//
// Usage:
//   Input beats on s_axis carry the two stick axes, the gimbal yaw and the measured
//   chassis velocities. Each beat yields exactly one output beat on m_axis with the
//   chassis-frame velocity targets in tdata and the saturation flag in tuser.
//   Registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i while idle.
// Pipeline:
//   The result of an accepted beat passes the cell chain (square root digits, divider
//   quotient bits and CORDIC micro-rotations, one per cell) and the registers around it,
//   and then the output register onto m_axis. One beat is accepted per cycle while the
//   skid register is empty.
// Reset:
//   Reset empties the pipeline and the output buffer and loads the register defaults
//   (max_speed 1.0, yaw_zero 0, remote_gain 1.0, comp_gain 0.02).
// Stall:
//   When m_axis_tready is low, the held result stays on m_axis and one further result
//   is caught in a skid register; the whole chain then freezes and s_axis_tready drops
//   until the skid register drains.
module stick_velocity_frame_rotate #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // stick_x, stick_y, yaw_angle, meas_vx, meas_vy, meas_wz from bit 0 up
  input  logic [95:0]  s_axis_tdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // out_vx, out_vy from bit 0 up
  output logic [31:0]  m_axis_tdata,
  // saturated
  output logic [0:0]   m_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [15:0]  cfg_wdata_i
);

  localparam int NSTG = 4 + 17 + 1 + 17 + 3 + CORDIC_STAGES + 5;

  logic [15:0]        max_speed_q, remote_gain_q, comp_gain_q;
  logic signed [15:0] yaw_zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q   <= 16'd256;
      yaw_zero_q    <= 16'sd0;
      remote_gain_q <= 16'd256;
      comp_gain_q   <= 16'd1311;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        svfr_pkg::CFG_MAX_SPEED:   max_speed_q   <= cfg_wdata_i;
        svfr_pkg::CFG_YAW_ZERO:    yaw_zero_q    <= $signed(cfg_wdata_i);
        svfr_pkg::CFG_REMOTE_GAIN: remote_gain_q <= cfg_wdata_i;
        svfr_pkg::CFG_COMP_GAIN:   comp_gain_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Flow control: the chain moves whenever the skid register is empty.
  logic ce, acc;
  logic out_valid_q, skid_valid_q;
  logic [NSTG-1:0] vld_q;

  assign ce            = !skid_valid_q;
  assign s_axis_tready = ce;
  assign acc           = s_axis_tvalid && ce;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ce) begin
      vld_q <= {vld_q[NSTG-2:0], acc};
    end
  end

  // ---------------- Stage 0: stick scaling and angle wrap ----------------
  logic signed [15:0] in_sx, in_sy, in_yaw, in_avx, in_avy, in_wz;
  assign in_sx  = $signed(s_axis_tdata[15:0]);
  assign in_sy  = $signed(s_axis_tdata[31:16]);
  assign in_yaw = $signed(s_axis_tdata[47:32]);
  assign in_avx = $signed(s_axis_tdata[63:48]);
  assign in_avy = $signed(s_axis_tdata[79:64]);
  assign in_wz  = $signed(s_axis_tdata[95:80]);

  logic signed [33:0] mx, my, rndx, rndy;
  assign mx   = -($signed({in_sx[15], in_sx}) * $signed({1'b0, max_speed_q}));
  assign my   = -($signed({in_sy[15], in_sy}) * $signed({1'b0, max_speed_q}));
  assign rndx = (mx + 34'sd16384) >>> 15;
  assign rndy = (my + 34'sd16384) >>> 15;

  logic signed [16:0] dang, dwr, rwr;
  assign dang = $signed({in_yaw[15], in_yaw}) - $signed({yaw_zero_q[15], yaw_zero_q});

  always_comb begin
    if (dang >= svfr_pkg::FOUR_PI_Q12) begin
      dwr = dang - svfr_pkg::FOUR_PI_Q12;
    end else if (dang >= svfr_pkg::TWO_PI_Q12) begin
      dwr = dang - svfr_pkg::TWO_PI_Q12;
    end else if (dang <= -svfr_pkg::FOUR_PI_Q12) begin
      dwr = dang + svfr_pkg::FOUR_PI_Q12;
    end else if (dang <= -svfr_pkg::TWO_PI_Q12) begin
      dwr = dang + svfr_pkg::TWO_PI_Q12;
    end else begin
      dwr = dang;
    end
    if (dwr > svfr_pkg::PI_Q12) begin
      rwr = dwr - svfr_pkg::TWO_PI_Q12;
    end else if (dwr < -svfr_pkg::PI_Q12) begin
      rwr = dwr + svfr_pkg::TWO_PI_Q12;
    end else begin
      rwr = dwr;
    end
  end

  logic signed [17:0] rx0_q, ry0_q;
  logic signed [15:0] ang0_q, avx0_q, avy0_q, wz0_q;

  // ---------------- Stage 1: magnitudes, limit, compensation gain ----------------
  logic signed [17:0] rxn, ryn;
  logic [16:0] ax1, ay1, lim1, awz;
  logic [32:0] kp1;
  assign rxn  = -rx0_q;
  assign ryn  = -ry0_q;
  assign ax1  = rx0_q[17] ? rxn[16:0] : rx0_q[16:0];
  assign ay1  = ry0_q[17] ? ryn[16:0] : ry0_q[16:0];
  assign lim1 = (ax1 > ay1) ? ax1 : ay1;
  assign awz  = wz0_q[15] ? (17'd0 - {wz0_q[15], wz0_q}) : {1'b0, wz0_q};
  assign kp1  = comp_gain_q * awz;

  logic [16:0] ax1_q, ay1_q;
  svfr_pkg::side_t side1_q, side2_q, side3_q;

  // ---------------- Stages 2 and 3: sum of squares ----------------
  logic [33:0] sqx2_q, sqy2_q;
  logic [35:0] n3_q;

  // ---------------- Square root chain ----------------
  logic [35:0]     sq_rem  [0:17];
  logic [16:0]     sq_root [0:17];
  svfr_pkg::side_t sq_side [0:17];

  assign sq_rem[0]  = n3_q;
  assign sq_root[0] = 17'd0;
  assign sq_side[0] = side3_q;

  for (genvar g = 0; g < 17; g++) begin : g_sqrt
    svfr_sqrt_cell #(.BIT(16 - g)) u_cell (
      .clk_i  (clk_i),
      .ce_i   (ce),
      .rem_i  (sq_rem[g]),
      .root_i (sq_root[g]),
      .side_i (sq_side[g]),
      .rem_o  (sq_rem[g+1]),
      .root_o (sq_root[g+1]),
      .side_o (sq_side[g+1])
    );
  end

  // ---------------- Divider setup: round(|v| * lim / spd) ----------------
  svfr_pkg::side_t sp;
  logic signed [17:0] prxn, pryn;
  logic [16:0] pax, pay, spd;
  logic [33:0] pmx, pmy;
  assign sp   = sq_side[17];
  assign spd  = sq_root[17];
  assign prxn = -sp.rx;
  assign pryn = -sp.ry;
  assign pax  = sp.rx[17] ? prxn[16:0] : sp.rx[16:0];
  assign pay  = sp.ry[17] ? pryn[16:0] : sp.ry[16:0];
  assign pmx  = pax * sp.lim;
  assign pmy  = pay * sp.lim;

  logic [35:0] numx_q, numy_q;
  logic [17:0] den_q;
  svfr_pkg::side_t sidep_q;

  logic [35:0]     dv_rx   [0:17];
  logic [35:0]     dv_ry   [0:17];
  logic [17:0]     dv_den  [0:17];
  logic [16:0]     dv_qx   [0:17];
  logic [16:0]     dv_qy   [0:17];
  svfr_pkg::side_t dv_side [0:17];

  assign dv_rx[0]   = numx_q;
  assign dv_ry[0]   = numy_q;
  assign dv_den[0]  = den_q;
  assign dv_qx[0]   = 17'd0;
  assign dv_qy[0]   = 17'd0;
  assign dv_side[0] = sidep_q;

  for (genvar g = 0; g < 17; g++) begin : g_div
    svfr_div_cell #(.BIT(16 - g)) u_cell (
      .clk_i  (clk_i),
      .ce_i   (ce),
      .remx_i (dv_rx[g]),
      .remy_i (dv_ry[g]),
      .den_i  (dv_den[g]),
      .qx_i   (dv_qx[g]),
      .qy_i   (dv_qy[g]),
      .side_i (dv_side[g]),
      .remx_o (dv_rx[g+1]),
      .remy_o (dv_ry[g+1]),
      .den_o  (dv_den[g+1]),
      .qx_o   (dv_qx[g+1]),
      .qy_o   (dv_qy[g+1]),
      .side_o (dv_side[g+1])
    );
  end

  // ---------------- Select normalized vector, apply gain, quarter turn ----------------
  svfr_pkg::side_t sd;
  logic signed [17:0] qxs, qys, nxs, nys;
  assign sd  = dv_side[17];
  assign qxs = sd.rx[17] ? -$signed({1'b0, dv_qx[17]}) : $signed({1'b0, dv_qx[17]});
  assign qys = sd.ry[17] ? -$signed({1'b0, dv_qy[17]}) : $signed({1'b0, dv_qy[17]});
  assign nxs = sd.norm ? qxs : sd.rx;
  assign nys = sd.norm ? qys : sd.ry;

  logic signed [17:0] nx_q, ny_q;
  svfr_pkg::side_t sides_q, sideg_q;

  logic signed [35:0] gxp, gyp;
  assign gxp = $signed({1'b0, remote_gain_q}) * ny_q;
  assign gyp = -($signed({1'b0, remote_gain_q}) * nx_q);

  logic signed [35:0] gx_q, gy_q;

  logic signed [15:0] qang, zlo;
  logic signed [35:0] qx, qy;
  assign qang = sideg_q.ang;

  always_comb begin
    if (qang > svfr_pkg::HALF_PI_Q12) begin
      qx  = -gy_q;
      qy  = gx_q;
      zlo = qang - svfr_pkg::HALF_PI_Q12;
    end else if (qang < -svfr_pkg::HALF_PI_Q12) begin
      qx  = gy_q;
      qy  = -gx_q;
      zlo = qang + svfr_pkg::HALF_PI_Q12;
    end else begin
      qx  = gx_q;
      qy  = gy_q;
      zlo = qang;
    end
  end

  // ---------------- CORDIC chain ----------------
  logic signed [35:0] cx [0:CORDIC_STAGES];
  logic signed [35:0] cy [0:CORDIC_STAGES];
  logic signed [31:0] cz [0:CORDIC_STAGES];
  svfr_pkg::side_t    cs [0:CORDIC_STAGES];

  logic signed [35:0] cx0_q, cy0_q;
  logic signed [31:0] cz0_q;
  svfr_pkg::side_t    cs0_q;

  assign cx[0] = cx0_q;
  assign cy[0] = cy0_q;
  assign cz[0] = cz0_q;
  assign cs[0] = cs0_q;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    svfr_cordic_cell #(.IDX(g)) u_cell (
      .clk_i  (clk_i),
      .ce_i   (ce),
      .x_i    (cx[g]),
      .y_i    (cy[g]),
      .z_i    (cz[g]),
      .side_i (cs[g]),
      .x_o    (cx[g+1]),
      .y_o    (cy[g+1]),
      .z_o    (cz[g+1]),
      .side_o (cs[g+1])
    );
  end

  // ---------------- Gain correction: x * 1/K split in two partial products ----------------
  logic signed [34:0] phx, phy;
  logic [33:0]        plx, ply;
  assign phx = $signed(cx[CORDIC_STAGES][35:18]) * svfr_pkg::INV_K_Q16;
  assign phy = $signed(cy[CORDIC_STAGES][35:18]) * svfr_pkg::INV_K_Q16;
  assign plx = cx[CORDIC_STAGES][17:0] * svfr_pkg::INV_K_Q16[15:0];
  assign ply = cy[CORDIC_STAGES][17:0] * svfr_pkg::INV_K_Q16[15:0];

  logic signed [34:0] phx_q, phy_q;
  logic [33:0]        plx_q, ply_q;
  svfr_pkg::side_t    sm1_q, sm2_q, sc0_q;

  logic signed [53:0] prx, pry, prrx, prry;
  assign prx  = $signed({phx_q[34], phx_q, 18'd0}) + $signed({20'd0, plx_q});
  assign pry  = $signed({phy_q[34], phy_q, 18'd0}) + $signed({20'd0, ply_q});
  assign prrx = (prx + 54'sd8388608) >>> 24;
  assign prry = (pry + 54'sd8388608) >>> 24;

  logic signed [26:0] tx2_q, ty2_q, tx0_q, ty0_q, tx1_q, ty1_q;
  logic signed [27:0] ex_q, ey_q;

  // ---------------- Compensation: kp * (t - a), kp split in halves ----------------
  logic signed [44:0] ehx, elx, ehy, ely;
  assign ehx = ex_q * $signed({1'b0, sc0_q.kp[31:16]});
  assign elx = ex_q * $signed({1'b0, sc0_q.kp[15:0]});
  assign ehy = ey_q * $signed({1'b0, sc0_q.kp[31:16]});
  assign ely = ey_q * $signed({1'b0, sc0_q.kp[15:0]});

  logic signed [44:0] ehx_q, elx_q, ehy_q, ely_q;

  logic signed [60:0] sumx, sumy, crx, cry;
  logic signed [37:0] ox, oy;
  logic signed [15:0] ovx, ovy;
  logic               satx, saty;
  assign sumx = $signed({ehx_q, 16'd0}) + $signed({{16{elx_q[44]}}, elx_q});
  assign sumy = $signed({ehy_q, 16'd0}) + $signed({{16{ely_q[44]}}, ely_q});
  assign crx  = (sumx + 61'sd8388608) >>> 24;
  assign cry  = (sumy + 61'sd8388608) >>> 24;
  assign ox   = $signed({{11{tx1_q[26]}}, tx1_q}) + crx[37:0];
  assign oy   = $signed({{11{ty1_q[26]}}, ty1_q}) + cry[37:0];

  always_comb begin
    satx = 1'b0;
    saty = 1'b0;
    if (ox > 38'sd32767) begin
      ovx  = 16'sh7FFF;
      satx = 1'b1;
    end else if (ox < -38'sd32768) begin
      ovx  = 16'sh8000;
      satx = 1'b1;
    end else begin
      ovx = ox[15:0];
    end
    if (oy > 38'sd32767) begin
      ovy  = 16'sh7FFF;
      saty = 1'b1;
    end else if (oy < -38'sd32768) begin
      ovy  = 16'sh8000;
      saty = 1'b1;
    end else begin
      ovy = oy[15:0];
    end
  end

  logic [31:0] res_q;
  logic        rsat_q;

  // ---------------- Payload registers of the chain ----------------
  always_ff @(posedge clk_i) begin
    if (ce) begin
      rx0_q  <= rndx[17:0];
      ry0_q  <= rndy[17:0];
      ang0_q <= rwr[15:0];
      avx0_q <= in_avx;
      avy0_q <= in_avy;
      wz0_q  <= in_wz;

      ax1_q        <= ax1;
      ay1_q        <= ay1;
      side1_q.rx   <= rx0_q;
      side1_q.ry   <= ry0_q;
      side1_q.lim  <= lim1;
      // The length exceeds the larger axis exactly when both axes are nonzero.
      side1_q.norm <= (ax1 != 17'd0) && (ay1 != 17'd0);
      side1_q.ang  <= ang0_q;
      side1_q.avx  <= avx0_q;
      side1_q.avy  <= avy0_q;
      side1_q.kp   <= kp1[31:0];

      sqx2_q  <= ax1_q * ax1_q;
      sqy2_q  <= ay1_q * ay1_q;
      side2_q <= side1_q;

      n3_q    <= {2'd0, sqx2_q} + {2'd0, sqy2_q};
      side3_q <= side2_q;

      numx_q  <= {1'b0, pmx, 1'b0} + {19'd0, spd};
      numy_q  <= {1'b0, pmy, 1'b0} + {19'd0, spd};
      den_q   <= {spd, 1'b0};
      sidep_q <= sp;

      nx_q    <= nxs;
      ny_q    <= nys;
      sides_q <= sd;

      gx_q    <= gxp;
      gy_q    <= gyp;
      sideg_q <= sides_q;

      cx0_q <= qx;
      cy0_q <= qy;
      cz0_q <= {zlo, 16'd0};
      cs0_q <= sideg_q;

      phx_q <= phx;
      phy_q <= phy;
      plx_q <= plx;
      ply_q <= ply;
      sm1_q <= cs[CORDIC_STAGES];

      tx2_q <= prrx[26:0];
      ty2_q <= prry[26:0];
      sm2_q <= sm1_q;

      tx0_q <= tx2_q;
      ty0_q <= ty2_q;
      ex_q  <= $signed({tx2_q[26], tx2_q}) - $signed({{12{sm2_q.avx[15]}}, sm2_q.avx});
      ey_q  <= $signed({ty2_q[26], ty2_q}) - $signed({{12{sm2_q.avy[15]}}, sm2_q.avy});
      sc0_q <= sm2_q;

      tx1_q <= tx0_q;
      ty1_q <= ty0_q;
      ehx_q <= ehx;
      elx_q <= elx;
      ehy_q <= ehy;
      ely_q <= ely;

      res_q  <= {ovy, ovx};
      rsat_q <= satx || saty;
    end
  end

  // ---------------- Output register with skid stage ----------------
  logic        pipe_v;
  logic [31:0] out_data_q, skid_data_q;
  logic        out_sat_q, skid_sat_q;

  assign pipe_v = vld_q[NSTG-1] && ce;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && !m_axis_tready) begin
      if (pipe_v) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= pipe_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && !m_axis_tready) begin
      if (pipe_v) begin
        skid_data_q <= res_q;
        skid_sat_q  <= rsat_q;
      end
    end else if (skid_valid_q) begin
      out_data_q <= skid_data_q;
      out_sat_q  <= skid_sat_q;
    end else if (pipe_v) begin
      out_data_q <= res_q;
      out_sat_q  <= rsat_q;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_sat_q;

  // ---------------- Assertions ----------------
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a beat while the output register is empty");

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted beat did not enter the first stage");

  a_frozen_chain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ce |=> $stable(vld_q))
    else $error("chain moved while the skid register was full");

  a_sat_extreme : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tdata[15:0] == 16'h7FFF || m_axis_tdata[15:0] == 16'h8000 ||
       m_axis_tdata[31:16] == 16'h7FFF || m_axis_tdata[31:16] == 16'h8000))
    else $error("saturation flag set without a clipped output");

endmodule
